[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bra_pkg.sv]
// Types and constants of the byte range lock table.
package bra_pkg;

  localparam int unsigned TableEntries = 16;

  localparam int unsigned OffsetW = 32;
  localparam int unsigned EndW    = OffsetW + 1;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    MODE_LOCK   = 1'b0,
    MODE_UNLOCK = 1'b1
  } mode_e;

  // Running OR terms handed from cell to cell.
  typedef struct packed {
    logic conflict;
    logic claimed;
    logic matched;
  } chain_t;

  // Update command broadcast to all cells in the commit cycle.
  typedef struct packed {
    logic lock_en;
    logic unlock_en;
  } cmd_t;

endpackage

[rtl/byte_range_lock_table.sv]
// Status: registered when the commit state completes, that is once the output is free.
// One request at a time: flag capture in all cells, then commit through the priority
// chain of cells; input is not ready until commit, which a stalled output holds back.
// Reset: asynchronous, clears all valid bits at once; no clearing pass, ready right after.
module byte_range_lock_table #(
  parameter int unsigned TABLE_ENTRIES = bra_pkg::TableEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] mode, [32:1] start_offset, [64:33] range_length, [71:65] zero
  input  logic [bra_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [7:2] zero
  output logic [bra_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam logic StIdle   = 1'b0;
  localparam logic StCommit = 1'b1;

  logic state_q, state_d;

  logic                        in_mode;
  logic [bra_pkg::OffsetW-1:0] in_start, in_len;
  logic [bra_pkg::EndW-1:0]    in_end;
  logic                        accept, commit;

  logic                        mode_q, len_zero_q;
  logic [bra_pkg::OffsetW-1:0] start_q;
  logic [bra_pkg::EndW-1:0]    end_q;

  logic                        out_valid_q;
  bra_pkg::status_e            status_q, status_d;

  bra_pkg::chain_t             chain [TABLE_ENTRIES+1];
  bra_pkg::cmd_t               cmd;

  assign in_mode  = s_axis_tdata[0];
  assign in_start = s_axis_tdata[32:1];
  assign in_len   = s_axis_tdata[64:33];
  assign in_end   = {1'b0, in_start} + {1'b0, in_len};

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == StCommit) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StCommit;
      StCommit: if (commit) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= in_mode;
      len_zero_q <= (in_len == '0);
      start_q    <= in_start;
      end_q      <= in_end;
    end
  end

  assign chain[0] = '0;

  assign cmd.lock_en   = commit && (mode_q == bra_pkg::MODE_LOCK) && !len_zero_q &&
                         !chain[TABLE_ENTRIES].conflict;
  assign cmd.unlock_en = commit && (mode_q == bra_pkg::MODE_UNLOCK) && !len_zero_q;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    bra_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .capture_i   (accept),
      .cmp_start_i (in_start),
      .cmp_end_i   (in_end),
      .wr_start_i  (start_q),
      .wr_end_i    (end_q),
      .cmd_i       (cmd),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1])
    );
  end

  always_comb begin
    if (len_zero_q) begin
      status_d = bra_pkg::ST_OK;
    end else if (mode_q == bra_pkg::MODE_LOCK) begin
      if (chain[TABLE_ENTRIES].conflict) begin
        status_d = bra_pkg::ST_CONFLICT;
      end else if (chain[TABLE_ENTRIES].claimed) begin
        status_d = bra_pkg::ST_OK;
      end else begin
        status_d = bra_pkg::ST_FULL;
      end
    end else if (chain[TABLE_ENTRIES].matched) begin
      status_d = bra_pkg::ST_OK;
    end else begin
      status_d = bra_pkg::ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bra_pkg::OutDataW-2){1'b0}}, status_q};

endmodule

[rtl/bra_cell.sv]
// One table entry: stored range, captured compare flags and chain logic.
module bra_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         capture_i,
  input  logic [bra_pkg::OffsetW-1:0]  cmp_start_i,
  input  logic [bra_pkg::EndW-1:0]     cmp_end_i,
  input  logic [bra_pkg::OffsetW-1:0]  wr_start_i,
  input  logic [bra_pkg::EndW-1:0]     wr_end_i,
  input  bra_pkg::cmd_t                cmd_i,
  input  bra_pkg::chain_t              chain_i,
  output bra_pkg::chain_t              chain_o
);

  logic                        valid_q;
  logic [bra_pkg::OffsetW-1:0] start_q;
  logic [bra_pkg::EndW-1:0]    end_q;
  logic                        conflict_q, match_q, free_q;
  logic                        conflict_d, match_d;
  logic                        take, release_en;

  assign conflict_d = valid_q && ({1'b0, cmp_start_i} < end_q) &&
                      (cmp_end_i >= {1'b0, start_q});
  assign match_d    = valid_q && (start_q == cmp_start_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conflict_q <= 1'b0;
      match_q    <= 1'b0;
      free_q     <= 1'b0;
    end else if (capture_i) begin
      conflict_q <= conflict_d;
      match_q    <= match_d;
      free_q     <= !valid_q;
    end
  end

  assign chain_o.conflict = chain_i.conflict | conflict_q;
  assign chain_o.claimed  = chain_i.claimed | free_q;
  assign chain_o.matched  = chain_i.matched | match_q;

  assign take       = cmd_i.lock_en && free_q && !chain_i.claimed;
  assign release_en = cmd_i.unlock_en && match_q && !chain_i.matched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (release_en) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      start_q <= wr_start_i;
      end_q   <= wr_end_i;
    end
  end

endmodule

[rtl/bra_checker.sv]
// Port-level checks of the byte range lock table, bound to the top level.
`include "assert_macros.svh"

module bra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [bra_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bra_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_acc, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_acc, !s_axis_tready)
  `ASSERT_IMPL(a_result_after_work, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))
  `ASSERT_NEXT(a_zero_len_ok, clk_i, rst_ni,
               in_acc && (s_axis_tdata[64:33] == '0) ##1 out_free,
               m_axis_tvalid && (m_axis_tdata[1:0] == bra_pkg::ST_OK))

endmodule

bind byte_range_lock_table bra_checker u_bra_checker (.*);
